[hdl/bia_pkg.sv]
// shared types, codes and a helper function of the bitmap id allocator
`timescale 1ns / 1ps
`default_nettype none

package bia_pkg;

  // fixed field and word widths
  localparam int WORD_W  = 32;
  localparam int POS_W   = 5;
  localparam int IDENT_W = 10;

  // command codes
  typedef enum logic {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } cmd_t;

  // status codes
  typedef enum logic {
    ST_OK   = 1'b0,
    ST_FAIL = 1'b1
  } status_t;

  localparam logic [WORD_W-1:0] WORD_ALL_ONES = 32'hffff_ffff;

  // position of the lowest clear bit of a word that is not all ones
  function automatic logic [POS_W-1:0] lowest_zero(input logic [WORD_W-1:0] w);
    logic [WORD_W-1:0] v;
    logic [POS_W-1:0]  pos;
    begin
      v   = w;
      pos = '0;
      if (v[15:0] == 16'hffff) begin
        pos[4] = 1'b1;
        v      = v >> 16;
      end
      if (v[7:0] == 8'hff) begin
        pos[3] = 1'b1;
        v      = v >> 8;
      end
      if (v[3:0] == 4'hf) begin
        pos[2] = 1'b1;
        v      = v >> 4;
      end
      if (v[1:0] == 2'h3) begin
        pos[1] = 1'b1;
        v      = v >> 2;
      end
      if (v[0]) begin
        pos[0] = 1'b1;
      end
      return pos;
    end
  endfunction

endpackage

`default_nettype wire

[hdl/bitmap_id_allocator_core.sv]
// bitmap id allocator: lowest-free-id allocate and free over a word memory
// result: strobe in the cycle after accept for a full map or out-of-range
// free, else after the memory read, then the modify and write-back state
// requests: a new request is taken only once the last one has left the modify state
// reset: a clearing pass writes every occupancy word to zero with busy high;
// results cannot be stalled by the receiver
`timescale 1ns / 1ps
`default_nettype none

module bitmap_id_allocator_core
  import bia_pkg::*;
#(
  parameter int ID_COUNT = 1024
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic               in_command,
  input  wire logic [IDENT_W-1:0] in_ident,
  output logic                    out_valid,
  output logic                    out_status,
  output logic      [IDENT_W-1:0] out_granted
);

  localparam int WORDS = (ID_COUNT + WORD_W - 1) / WORD_W;
  localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int IXW   = AW + POS_W;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_MOD
  } state_t;

  state_t             state_r;
  logic [AW-1:0]      clr_cnt_r;
  logic [AW-1:0]      addr_r;
  logic               cmd_r;
  logic [IDENT_W-1:0] ident_r;
  logic               out_valid_r;
  logic               out_status_r;
  logic [IDENT_W-1:0] out_granted_r;

  logic               accept;
  logic [IXW-1:0]     ident_ext;
  logic [AW-1:0]      ident_word;
  logic               ident_in_range;
  logic               any_free;
  logic [AW-1:0]      first_free;
  logic [AW-1:0]      rd_addr;
  logic [WORD_W-1:0]  rd_word;
  logic [POS_W-1:0]   zero_pos;
  logic [IXW-1:0]     alloc_idx;
  logic               alloc_ok;
  logic [WORD_W-1:0]  mod_word;
  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  logic [WORD_W-1:0]  mem_wdata;
  logic               trk_upd;

  assign accept = start && !busy;
  assign busy   = (state_r != S_IDLE);

  // word of the request identifier and range check
  assign ident_ext      = IXW'(in_ident);
  assign ident_word     = ident_ext[IXW-1:POS_W];
  assign ident_in_range = (32'(in_ident) < 32'(ID_COUNT));

  // read address: first non-full word for allocate, named word for free
  assign rd_addr = (in_command == CMD_FREE) ? ident_word : first_free;

  // modify step on the word read back
  assign zero_pos  = lowest_zero(rd_word);
  assign alloc_idx = {addr_r, zero_pos};
  assign alloc_ok  = (32'(alloc_idx) < 32'(ID_COUNT));

  always_comb begin
    if (cmd_r == CMD_FREE) begin
      mod_word = rd_word & ~(WORD_W'(1) << ident_r[POS_W-1:0]);
    end else begin
      mod_word = rd_word | (WORD_W'(1) << zero_pos);
    end
  end

  // memory write: clearing pass or write-back
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = addr_r;
    mem_wdata = mod_word;
    trk_upd   = 1'b0;
    unique case (state_r)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_cnt_r;
        mem_wdata = '0;
      end
      S_MOD: begin
        mem_we  = (cmd_r == CMD_FREE) || alloc_ok;
        trk_upd = mem_we;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  bia_occ_mem #(
    .DEPTH (WORDS),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (rd_addr),
    .rdata (rd_word)
  );

  bia_word_track #(
    .WORDS (WORDS),
    .AW    (AW)
  ) u_track (
    .clk        (clk),
    .rst_n      (rst_n),
    .upd        (trk_upd),
    .upd_addr   (addr_r),
    .upd_full   (mod_word == WORD_ALL_ONES),
    .any_free   (any_free),
    .first_free (first_free)
  );

  // control state and registered results
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      unique case (state_r)
        S_CLEAR: begin
          clr_cnt_r <= clr_cnt_r + AW'(1);
          if (32'(clr_cnt_r) == 32'(WORDS - 1)) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            cmd_r   <= in_command;
            ident_r <= in_ident;
            addr_r  <= rd_addr;
            if (in_command == CMD_FREE) begin
              if (ident_in_range) begin
                state_r <= S_MOD;
              end else begin
                out_valid_r   <= 1'b1;
                out_status_r  <= ST_FAIL;
                out_granted_r <= in_ident;
              end
            end else begin
              if (any_free) begin
                state_r <= S_MOD;
              end else begin
                out_valid_r   <= 1'b1;
                out_status_r  <= ST_FAIL;
                out_granted_r <= '0;
              end
            end
          end
        end
        S_MOD: begin
          state_r     <= S_IDLE;
          out_valid_r <= 1'b1;
          if (cmd_r == CMD_FREE) begin
            out_status_r  <= ST_OK;
            out_granted_r <= ident_r;
          end else if (alloc_ok) begin
            out_status_r  <= ST_OK;
            out_granted_r <= IDENT_W'(32'(alloc_idx));
          end else begin
            out_status_r  <= ST_FAIL;
            out_granted_r <= '0;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid   = out_valid_r;
  assign out_status  = out_status_r;
  assign out_granted = out_granted_r;

  // a result only follows an accepted request or a modify cycle
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($past(accept) || $past(state_r == S_MOD)))
    else $error("result without a request");

  // a failed allocate always reports identifier zero
  a_full_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_FAIL && cmd_r == CMD_ALLOC) |-> (out_granted == '0))
    else $error("full allocate with nonzero identifier");

  // memory is only written by the clearing pass or a write-back
  a_write_source: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (state_r == S_CLEAR || state_r == S_MOD))
    else $error("stray memory write");

  // no request is taken before the clearing pass ends
  a_clear_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLEAR) |-> busy)
    else $error("not busy during clearing pass");

endmodule

`default_nettype wire

[hdl/bia_occ_mem.sv]
// occupancy word memory, one write and one registered read port
`timescale 1ns / 1ps
`default_nettype none

module bia_occ_mem
  import bia_pkg::*;
#(
  parameter int DEPTH = 32,
  parameter int AW    = 5
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [AW-1:0]     waddr,
  input  wire logic [WORD_W-1:0] wdata,
  input  wire logic [AW-1:0]     raddr,
  output logic      [WORD_W-1:0] rdata
);

  logic [WORD_W-1:0] mem [DEPTH];
  logic [WORD_W-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, registered
  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

[hdl/bia_word_track.sv]
// full-word summary register and first non-full word encoder
`timescale 1ns / 1ps
`default_nettype none

module bia_word_track
  import bia_pkg::*;
#(
  parameter int WORDS = 32,
  parameter int AW    = 5
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          upd,
  input  wire logic [AW-1:0] upd_addr,
  input  wire logic          upd_full,
  output logic               any_free,
  output logic      [AW-1:0] first_free
);

  logic [WORDS-1:0] full_r;
  logic [WORDS-1:0] full_nxt;

  // one bit per word, set when the word is all ones
  always_comb begin
    full_nxt = full_r;
    if (upd) begin
      full_nxt[upd_addr] = upd_full;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      full_r <= '0;
    end else begin
      full_r <= full_nxt;
    end
  end

  // lowest word with a clear bit
  always_comb begin
    first_free = '0;
    for (int i = WORDS - 1; i >= 0; i--) begin
      if (!full_r[i]) begin
        first_free = AW'(i);
      end
    end
  end

  assign any_free = ~(&full_r);

endmodule

`default_nettype wire
